// ===== src/weekly_relay_schedule_engine_assert.svh =====
// ----------------------------------------------------------------------------
// weekly relay schedule engine assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef WEEKLY_RELAY_SCHEDULE_ENGINE_ASSERT_SVH
`define WEEKLY_RELAY_SCHEDULE_ENGINE_ASSERT_SVH

// same-cycle implication
`define WRSE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wrse assertion failed");

// next-cycle implication
`define WRSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wrse assertion failed");

`endif

// ===== src/wrse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrse_pkg
// types and constants of the weekly relay schedule engine
// ----------------------------------------------------------------------------
package wrse_pkg;

  localparam int DEF_TIMER_SLOTS = 16;

  localparam int KIND_W   = 2;
  localparam int MINUTE_W = 11;
  localparam int SECOND_W = 6;
  localparam int WDAY_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int DAYS_W   = 8;
  localparam int ACTION_W = 8;
  localparam int COUNT_W  = 8;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COUNT = 2'd2;

  localparam logic [MINUTE_W-1:0] LAST_MINUTE     = 11'd1439;
  localparam logic [ACTION_W-1:0] ACT_OFF         = 8'd0;
  localparam logic [ACTION_W-1:0] ACT_ON          = 8'd1;
  localparam logic [ACTION_W-1:0] ACT_TIMED_FIRST = 8'd5;
  localparam logic [ACTION_W-1:0] ACT_TIMED_END   = 8'd60;

  typedef struct packed {
    logic                en;
    logic [DAYS_W-1:0]   days;
    logic [ACTION_W-1:0] action;
    logic [MINUTE_W-1:0] minute;
  } entry_t;

  typedef struct packed {
    logic invalid;
    logic fire;
    logic act;
    logic clear_en;
  } fire_t;

endpackage

// ===== src/wrse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrse channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface wrse_in_if import wrse_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [MINUTE_W-1:0] minute_of_day;
  logic [SECOND_W-1:0] second;
  logic [WDAY_W-1:0]   weekday;
  logic                sensor_override;
  logic [SLOT_W-1:0]   slot;
  logic                entry_enable;
  logic [DAYS_W-1:0]   entry_repeat;
  logic [ACTION_W-1:0] entry_action;
  logic [MINUTE_W-1:0] entry_time;
  logic [COUNT_W-1:0]  new_count;

  modport source (
    output valid, kind, minute_of_day, second, weekday, sensor_override, slot,
           entry_enable, entry_repeat, entry_action, entry_time, new_count,
    input  ready
  );
  modport sink (
    input  valid, kind, minute_of_day, second, weekday, sensor_override, slot,
           entry_enable, entry_repeat, entry_action, entry_time, new_count,
    output ready
  );
endinterface

interface wrse_out_if import wrse_pkg::*;;
  logic               valid;
  logic               ready;
  logic               switched;
  logic               relay_on;
  logic [COUNT_W-1:0] active_entries;

  modport source (output valid, switched, relay_on, active_entries, input ready);
  modport sink (input valid, switched, relay_on, active_entries, output ready);
endinterface

// ===== src/weekly_relay_schedule_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weekly_relay_schedule_engine
// slot table and tick walker that drive one relay from a weekly schedule
// ----------------------------------------------------------------------------
// Every item gives one result beat. A slot write, a count write, an unused
// kind or a tick under sensor override goes from acceptance straight to the
// finish state; the result register loads there once the output register is
// free, and the input is ready again after that load. A tick first walks
// the first N slots, where N is the entry count (at most TIMER_SLOTS; a count
// above TIMER_SLOTS is treated as zero): the walk reads one slot per cycle
// from the slot memory's single read port and writes a cleared enable back
// in the next cycle on the write port. The walk stops early at the first
// invalid slot. A finished result waits in the output register while the next
// item is taken; if the next result is ready before that beat leaves, the
// engine holds until the output register frees up. No clearing pass follows
// reset: slots never written read as zero.
module weekly_relay_schedule_engine import wrse_pkg::*; #(
  parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
  input logic        clk,
  input logic        rst_n,
  wrse_in_if.sink    in_ch,
  wrse_out_if.source out_ch
);

  `include "weekly_relay_schedule_engine_assert.svh"

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   ev_idx_r, ev_idx_nxt;
  logic               ev_vld_r, ev_vld_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               relay_r, relay_nxt;
  logic               flag_r, flag_nxt;
  logic               act_r, act_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic               out_sw_r, out_sw_nxt;
  logic               out_relay_r, out_relay_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic [MINUTE_W-1:0] tk_min_r;
  logic [SECOND_W-1:0] tk_sec_r;
  logic [WDAY_W-1:0]   tk_wd_r;

  logic             in_acc;
  logic             stop;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           rd_entry;
  fire_t            fr;

  wrse_slot_mem #(
    .DEPTH (TIMER_SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_entry)
  );

  wrse_fire_eval u_eval (
    .entry  (rd_entry),
    .tk_min (tk_min_r),
    .tk_sec (tk_sec_r),
    .tk_wd  (tk_wd_r),
    .res    (fr)
  );

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);

  assign out_ch.valid          = out_vld_r;
  assign out_ch.switched       = out_sw_r;
  assign out_ch.relay_on       = out_relay_r;
  assign out_ch.active_entries = out_cnt_r;

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    ev_idx_nxt    = ev_idx_r;
    ev_vld_nxt    = ev_vld_r;
    cnt_nxt       = cnt_r;
    relay_nxt     = relay_r;
    flag_nxt      = flag_r;
    act_nxt       = act_r;
    out_vld_nxt   = out_vld_r;
    out_sw_nxt    = out_sw_r;
    out_relay_nxt = out_relay_r;
    out_cnt_nxt   = out_cnt_r;
    stop          = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = '0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          flag_nxt  = 1'b0;
          act_nxt   = 1'b0;
          state_nxt = ST_FIN;
          unique case (in_ch.kind)
            KIND_TICK: begin
              if (!in_ch.sensor_override) begin
                cnt_nxt    = (cnt_r > COUNT_W'(TIMER_SLOTS)) ? '0 : cnt_r;
                rd_idx_nxt = '0;
                ev_vld_nxt = 1'b0;
                state_nxt  = ST_WALK;
              end
            end
            KIND_WRITE: begin
              if (32'(in_ch.slot) < TIMER_SLOTS) begin
                mem_wr_en          = 1'b1;
                mem_wr_addr        = IDX_W'(in_ch.slot);
                mem_wr_data.en     = in_ch.entry_enable;
                mem_wr_data.days   = in_ch.entry_repeat;
                mem_wr_data.action = in_ch.entry_action;
                mem_wr_data.minute = in_ch.entry_time;
              end
            end
            KIND_COUNT: begin
              cnt_nxt = in_ch.new_count;
            end
            default: begin
            end
          endcase
        end
      end

      ST_WALK: begin
        // evaluate the slot read last cycle; write-back hits a slot already
        // passed, so it never collides with the read issued alongside
        if (ev_vld_r) begin
          if (fr.invalid) begin
            cnt_nxt = COUNT_W'(ev_idx_r);
            stop    = 1'b1;
          end else if (fr.fire) begin
            flag_nxt = 1'b1;
            act_nxt  = fr.act;
            if (fr.clear_en) begin
              mem_wr_en      = 1'b1;
              mem_wr_addr    = IDX_W'(ev_idx_r);
              mem_wr_data    = rd_entry;
              mem_wr_data.en = 1'b0;
            end
          end
        end

        if (stop) begin
          ev_vld_nxt = 1'b0;
          state_nxt  = ST_FIN;
        end else if (COUNT_W'(rd_idx_r) < cnt_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = IDX_W'(rd_idx_r);
          rd_idx_nxt  = CNT_W'(rd_idx_r + 1'b1);
          ev_idx_nxt  = rd_idx_r;
          ev_vld_nxt  = 1'b1;
        end else begin
          ev_vld_nxt = 1'b0;
          state_nxt  = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_vld_r || out_ch.ready) begin
          relay_nxt     = flag_r ? act_r : relay_r;
          out_vld_nxt   = 1'b1;
          out_sw_nxt    = flag_r;
          out_relay_nxt = relay_nxt;
          out_cnt_nxt   = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_idx_r  <= '0;
      ev_vld_r  <= 1'b0;
      cnt_r     <= '0;
      relay_r   <= 1'b0;
      flag_r    <= 1'b0;
      act_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      ev_vld_r  <= ev_vld_nxt;
      cnt_r     <= cnt_nxt;
      relay_r   <= relay_nxt;
      flag_r    <= flag_nxt;
      act_r     <= act_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r    <= ev_idx_nxt;
    out_sw_r    <= out_sw_nxt;
    out_relay_r <= out_relay_nxt;
    out_cnt_r   <= out_cnt_nxt;
    if (in_acc) begin
      tk_min_r <= in_ch.minute_of_day;
      tk_sec_r <= in_ch.second;
      tk_wd_r  <= in_ch.weekday;
    end
  end

  `WRSE_ASSERT_IMPL(a_walk_cnt_clamped, state_r == ST_WALK, cnt_r <= COUNT_W'(TIMER_SLOTS))
  `WRSE_ASSERT_IMPL(a_eval_in_range, (state_r == ST_WALK) && ev_vld_r,
                    COUNT_W'(ev_idx_r) < cnt_r)
  `WRSE_ASSERT_IMPL(a_relay_change_reported, !$stable(relay_r),
                    out_ch.valid && out_ch.switched)
  `WRSE_ASSERT_IMPL(a_result_from_fin, $rose(out_ch.valid), $past(state_r) == ST_FIN)
  `WRSE_ASSERT_NEXT(a_one_item_at_a_time, in_acc, !in_ch.ready)

endmodule

// ===== src/wrse_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrse_slot_mem
// schedule slot memory, one write and one registered read port per cycle
// ----------------------------------------------------------------------------
module wrse_slot_mem import wrse_pkg::*; #(
  parameter int DEPTH = DEF_TIMER_SLOTS,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t           mem_r [DEPTH];
  entry_t           rd_q_r;
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  // per-entry written flags stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== src/wrse_fire_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrse_fire_eval
// checks one schedule entry against the current tick
// ----------------------------------------------------------------------------
module wrse_fire_eval import wrse_pkg::*; (
  input  entry_t              entry,
  input  logic [MINUTE_W-1:0] tk_min,
  input  logic [SECOND_W-1:0] tk_sec,
  input  logic [WDAY_W-1:0]   tk_wd,
  output fire_t               res
);

  logic bad_min;
  logic bad_act;
  logic match;
  logic day;
  logic one_shot;
  logic timed;

  always_comb begin
    bad_min  = entry.minute > LAST_MINUTE;
    bad_act  = (entry.action > ACT_ON && entry.action < ACT_TIMED_FIRST) ||
               (entry.action >= ACT_TIMED_END);
    match    = entry.en && (entry.minute == tk_min) && !bad_min && !bad_act;
    day      = entry.days[tk_wd];
    one_shot = (entry.days == '0);
    timed    = (entry.action >= ACT_TIMED_FIRST) && (entry.action < ACT_TIMED_END) &&
               (ACTION_W'(tk_sec) == entry.action);

    res         = '0;
    res.invalid = bad_min || bad_act;
    if (match) begin
      if (tk_sec == '0) begin
        if (one_shot) begin
          res.fire     = 1'b1;
          res.act      = entry.action != ACT_OFF;
          res.clear_en = (entry.action == ACT_OFF) || (entry.action == ACT_ON);
        end else if (day) begin
          res.fire = 1'b1;
          res.act  = entry.action != ACT_OFF;
        end
      end else if (timed) begin
        // timed-off second of an on-then-off entry
        if (one_shot) begin
          res.fire     = 1'b1;
          res.clear_en = 1'b1;
        end else if (day) begin
          res.fire = 1'b1;
        end
      end
    end
  end

endmodule
